// ===== hdl/mlfd_pkg.sv =====
// Package for the multi-lane FIFO dispatcher.
// Holds field widths, lane geometry, operation and status codes shared by the interfaces
// and modules. No dependencies.
package mlfd_pkg;

    localparam int ID_WIDTH     = 48;
    localparam int MODE_WIDTH   = 2;
    localparam int LANE_WIDTH   = 2;
    localparam int STATUS_WIDTH = 2;
    localparam int CFG_WIDTH    = 3;

    localparam int NUM_LANES    = 4;
    localparam int LANE_DEPTH   = 16;
    localparam int SEQ_WIDTH    = 16;
    localparam int CNT_WIDTH    = $clog2(LANE_DEPTH + 1);

    typedef logic [MODE_WIDTH-1:0]   t_mode;
    typedef logic [STATUS_WIDTH-1:0] t_status;
    typedef logic [LANE_WIDTH-1:0]   t_lane;
    typedef logic [ID_WIDTH-1:0]     t_id;
    typedef logic [CFG_WIDTH-1:0]    t_cfg;
    typedef logic [SEQ_WIDTH-1:0]    t_seq;
    typedef logic [CNT_WIDTH-1:0]    t_count;

    localparam t_mode MODE_INSERT = 2'd0;
    localparam t_mode MODE_REMOVE = 2'd1;
    localparam t_mode MODE_QUERY  = 2'd2;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_FULL  = 2'd2;

    localparam t_cfg CFG_LANES_RESET = 3'd4;

endpackage

// ===== hdl/mlfd_if.sv =====
// Channel interfaces of the multi-lane FIFO dispatcher: request, response, configuration.
// Each carries valid, ready and its payload; depends on mlfd_pkg.
interface mlfd_req_if;
    logic              valid;
    logic              ready;
    mlfd_pkg::t_mode   mode;
    mlfd_pkg::t_id     item_id;
    logic              batch_start;
    mlfd_pkg::t_lane   lane;

    modport source (output valid, mode, item_id, batch_start, lane, input ready);
    modport sink   (input valid, mode, item_id, batch_start, lane, output ready);
endinterface

interface mlfd_rsp_if;
    logic                  valid;
    logic                  ready;
    mlfd_pkg::t_status     status;
    mlfd_pkg::t_lane       lane_used;
    mlfd_pkg::t_seq        assigned_sequence;
    mlfd_pkg::t_id         head_id;
    mlfd_pkg::t_seq        head_sequence;
    mlfd_pkg::t_seq        tail_sequence;
    mlfd_pkg::t_count      lane_count;
    logic                  lane_empty;

    modport source (output valid, status, lane_used, assigned_sequence, head_id,
                    head_sequence, tail_sequence, lane_count, lane_empty, input ready);
    modport sink   (input valid, status, lane_used, assigned_sequence, head_id,
                    head_sequence, tail_sequence, lane_count, lane_empty, output ready);
endinterface

interface mlfd_cfg_if;
    logic            valid;
    logic            ready;
    mlfd_pkg::t_cfg  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/multi_lane_fifo_dispatcher.sv =====
// Top level of the multi-lane FIFO dispatcher: lane control, sequence numbering, dispatch.
// Depends on mlfd_pkg, the channel interfaces in mlfd_if and the entry store mlfd_store.
//
// Usage:
//   i_req carries one request: insert an item, remove a lane's head, or query a lane.
//   o_rsp returns one response per request, in order: status, lane acted on, the
//   sequence given to an inserted item, and the lane's head, tail and count afterward.
//   i_cfg writes lanes_in_use; it is always ready. It is to be written only while idle;
//   the block does not enforce it. Requests go via the input and result registers.
//   Throughput: one request per cycle while o_rsp.ready is high; the per-lane pointer,
//   count and tail-sequence registers are updated in the same cycle that the store is
//   written and its head entry read, so only back-pressure limits the rate below one.
//   Reset: every lane empty, round robin at lane 0, lanes_in_use 4. The entry store
//   needs no clearing: only written entries are ever reported.
//   Stall: while o_rsp.ready is low the response holds; one more request is taken
//   into the input register, then i_req.ready falls until the response leaves.
module multi_lane_fifo_dispatcher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mlfd_cfg_if.sink   i_cfg,
    mlfd_req_if.sink   i_req,
    mlfd_rsp_if.source o_rsp
);

    localparam int NUM_LANES  = mlfd_pkg::NUM_LANES;
    localparam int LANE_DEPTH = mlfd_pkg::LANE_DEPTH;
    localparam int SEQ_WIDTH  = mlfd_pkg::SEQ_WIDTH;
    localparam int LNW = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
    localparam int PW  = $clog2(LANE_DEPTH);
    localparam int CW  = mlfd_pkg::CNT_WIDTH;
    localparam int AW  = $clog2(NUM_LANES * LANE_DEPTH);
    localparam int DW  = mlfd_pkg::ID_WIDTH + SEQ_WIDTH;
    localparam logic [4:0]           NL5     = 5'(NUM_LANES);
    localparam logic [CW-1:0]        CNT_MAX = CW'(LANE_DEPTH);
    localparam logic [PW-1:0]        PTR_MAX = PW'(LANE_DEPTH - 1);
    localparam logic [SEQ_WIDTH-1:0] SEQ_MAX = {SEQ_WIDTH{1'b1}};

    // configuration
    mlfd_pkg::t_cfg r_cfg;

    // input register
    logic                r_v1;
    mlfd_pkg::t_mode     r_mode;
    mlfd_pkg::t_id       r_id;
    logic                r_batch;
    mlfd_pkg::t_lane     r_lane;

    // lane state
    logic [PW-1:0]        r_hp [NUM_LANES];
    logic [PW-1:0]        r_tp [NUM_LANES];
    logic [CW-1:0]        r_cnt [NUM_LANES];
    logic [SEQ_WIDTH-1:0] r_ts [NUM_LANES];
    logic [LNW-1:0]       r_next_lane;
    logic [PW-1:0]        n_hp [NUM_LANES];
    logic [PW-1:0]        n_tp [NUM_LANES];
    logic [CW-1:0]        n_cnt [NUM_LANES];
    logic [SEQ_WIDTH-1:0] n_ts [NUM_LANES];
    logic [LNW-1:0]       n_next_lane;

    // result register
    logic                 r_v2;
    mlfd_pkg::t_status    r_status;
    mlfd_pkg::t_lane      r_lane_used;
    logic [SEQ_WIDTH-1:0] r_assigned;
    logic [SEQ_WIDTH-1:0] r_tail;
    logic [CW-1:0]        r_count;
    logic                 r_empty;

    logic                 adv2;
    logic                 adv1;
    logic [4:0]           act;
    logic [4:0]           lane_mod;
    logic [LNW-1:0]       sel_lane;
    logic [SEQ_WIDTH-1:0] top_seq;
    logic [SEQ_WIDTH-1:0] new_seq;
    logic [LNW-1:0]       empty_lane;
    logic                 have_empty;
    logic [LNW-1:0]       min_lane;
    logic [SEQ_WIDTH-1:0] min_seq;
    logic                 have_min;
    logic [LNW-1:0]       start_lane;
    logic [LNW-1:0]       l;
    logic [4:0]           l5;
    mlfd_pkg::t_status    status;
    logic [SEQ_WIDTH-1:0] assigned;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [DW-1:0]        rd_data;

    assign adv2        = !r_v2 || o_rsp.ready;
    assign adv1        = r_v1 && adv2;
    assign i_req.ready = !r_v1 || adv2;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= mlfd_pkg::CFG_LANES_RESET;
        end else if (i_cfg.valid) begin
            r_cfg <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_req.ready) begin
            r_v1 <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_mode  <= i_req.mode;
            r_id    <= i_req.item_id;
            r_batch <= i_req.batch_start;
            r_lane  <= i_req.lane;
        end
    end

    always_comb begin
        if (r_cfg == '0) begin
            act = 5'd1;
        end else if (5'(r_cfg) > NL5) begin
            act = NL5;
        end else begin
            act = 5'(r_cfg);
        end
    end

    always_comb begin
        lane_mod = 5'(r_lane);
        for (int k = 0; k < 3; k++) begin
            if (lane_mod >= NL5) begin
                lane_mod = lane_mod - NL5;
            end
        end
        sel_lane = lane_mod[LNW-1:0];
    end

    always_comb begin
        top_seq    = '0;
        have_empty = 1'b0;
        empty_lane = '0;
        have_min   = 1'b0;
        min_lane   = '0;
        min_seq    = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            if (5'(i) < act && r_cnt[i] != '0 && r_ts[i] > top_seq) begin
                top_seq = r_ts[i];
            end
            if (5'(i) < act && (!have_min || r_ts[i] < min_seq)) begin
                have_min = 1'b1;
                min_lane = LNW'(i);
                min_seq  = r_ts[i];
            end
        end
        for (int i = NUM_LANES - 1; i >= 0; i--) begin
            if (5'(i) < act && r_cnt[i] == '0) begin
                have_empty = 1'b1;
                empty_lane = LNW'(i);
            end
        end
        start_lane = have_empty ? empty_lane : min_lane;
        new_seq    = (top_seq == SEQ_MAX) ? SEQ_MAX : top_seq + 1'b1;
    end

    always_comb begin
        n_hp        = r_hp;
        n_tp        = r_tp;
        n_cnt       = r_cnt;
        n_ts        = r_ts;
        n_next_lane = r_next_lane;
        status      = mlfd_pkg::STATUS_OK;
        assigned    = '0;
        wr_en       = 1'b0;
        l           = sel_lane;
        unique case (r_mode)
            mlfd_pkg::MODE_INSERT: begin
                if (r_batch) begin
                    l = start_lane;
                end else begin
                    l = (5'(r_next_lane) < act) ? r_next_lane : '0;
                end
                if (adv1) begin
                    n_next_lane = (5'(l) + 5'd1 < act) ? LNW'(5'(l) + 5'd1) : '0;
                end
                if (r_cnt[l] >= CNT_MAX) begin
                    status = mlfd_pkg::STATUS_FULL;
                end else begin
                    assigned = new_seq;
                    wr_en    = adv1;
                    if (adv1) begin
                        n_tp[l]  = (r_tp[l] == PTR_MAX) ? '0 : r_tp[l] + 1'b1;
                        n_cnt[l] = r_cnt[l] + 1'b1;
                        n_ts[l]  = new_seq;
                    end
                end
            end
            mlfd_pkg::MODE_REMOVE: begin
                if (r_cnt[l] == '0) begin
                    status = mlfd_pkg::STATUS_EMPTY;
                end else if (adv1) begin
                    n_hp[l]  = (r_hp[l] == PTR_MAX) ? '0 : r_hp[l] + 1'b1;
                    n_cnt[l] = r_cnt[l] - 1'b1;
                    if (r_cnt[l] == CW'(1)) begin
                        n_ts[l] = '0;
                    end
                end
            end
            default: begin
            end
        endcase
        l5      = 5'(l);
        wr_addr = AW'(int'(l) * LANE_DEPTH + int'(r_tp[l]));
        rd_addr = AW'(int'(l) * LANE_DEPTH + int'(n_hp[l]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                r_hp[i]  <= '0;
                r_tp[i]  <= '0;
                r_cnt[i] <= '0;
                r_ts[i]  <= '0;
            end
            r_next_lane <= '0;
        end else begin
            r_hp        <= n_hp;
            r_tp        <= n_tp;
            r_cnt       <= n_cnt;
            r_ts        <= n_ts;
            r_next_lane <= n_next_lane;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_status    <= status;
            r_lane_used <= l5[1:0];
            r_assigned  <= assigned;
            r_tail      <= n_ts[l];
            r_count     <= n_cnt[l];
            r_empty     <= (n_cnt[l] == '0);
        end
    end

    mlfd_store #(
        .DEPTH      (NUM_LANES * LANE_DEPTH),
        .ADDR_WIDTH (AW),
        .DATA_WIDTH (DW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ({r_id, new_seq}),
        .i_rd_en   (adv1),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_rsp.valid             = r_v2;
    assign o_rsp.status            = r_status;
    assign o_rsp.lane_used         = r_lane_used;
    assign o_rsp.assigned_sequence = r_assigned;
    assign o_rsp.head_id           = r_empty ? '0 : rd_data[DW-1:SEQ_WIDTH];
    assign o_rsp.head_sequence     = r_empty ? '0 : rd_data[SEQ_WIDTH-1:0];
    assign o_rsp.tail_sequence     = r_tail;
    assign o_rsp.lane_count        = r_count;
    assign o_rsp.lane_empty        = r_empty;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_chk
        a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_cnt[g] <= CNT_MAX)
            else $error("lane count above depth");
        a_empty_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_cnt[g] == '0 |-> r_ts[g] == '0)
            else $error("empty lane keeps a tail sequence");
        a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_cnt[g] == '0 || r_cnt[g] == CNT_MAX) |-> r_hp[g] == r_tp[g])
            else $error("lane pointers disagree with count");
    end

    a_full_no_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && r_status == mlfd_pkg::STATUS_FULL |-> r_assigned == '0)
        else $error("dropped insert reports a sequence");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !adv2 |=> r_v1 && $stable(r_mode) && $stable(r_lane))
        else $error("input register lost a request during stall");

endmodule

// ===== hdl/mlfd_store.sv =====
// Entry store of the dispatcher: one write port, one registered read port.
// A read at the address written in the same cycle returns the new data.
// No package dependencies.
module mlfd_store #(
    parameter int DEPTH      = 64,
    parameter int ADDR_WIDTH = 6,
    parameter int DATA_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [ADDR_WIDTH-1:0] i_wr_addr,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    input  logic                  i_rd_en,
    input  logic [ADDR_WIDTH-1:0] i_rd_addr,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [DATA_WIDTH-1:0] r_wr_data;
    logic                  r_bypass;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_wr_data <= i_wr_data;
            r_bypass  <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_bypass ? r_wr_data : r_rd_data;

endmodule

// ===== test/mlfd_checker.sv =====
// Checker for the multi-lane FIFO dispatcher: watches the configuration, request and
// response channels, predicts every response and compares it field by field.
// Depends on mlfd_pkg and the channel interfaces in mlfd_if.
module mlfd_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mlfd_cfg_if  i_cfg,
    mlfd_req_if  i_req,
    mlfd_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LANES     = mlfd_pkg::NUM_LANES;
    localparam int DEPTH     = mlfd_pkg::LANE_DEPTH;
    localparam int SEQ_TOP   = 65535;
    localparam int PRINT_CAP = 100;

    typedef struct packed {
        mlfd_pkg::t_status status;
        mlfd_pkg::t_lane   lane_used;
        logic [15:0]       assigned;
        mlfd_pkg::t_id     head_id;
        logic [15:0]       head_seq;
        logic [15:0]       tail_seq;
        logic [4:0]        count;
        logic              empty;
    } t_lane_result;

    mlfd_pkg::t_id  slot_id  [LANES][DEPTH];
    logic [15:0]    slot_seq [LANES][DEPTH];
    logic [3:0]     rd_ptr   [LANES];
    logic [3:0]     wr_ptr   [LANES];
    logic [4:0]     fill     [LANES];
    logic [15:0]    last_seq [LANES];
    int unsigned    rr_lane;
    mlfd_pkg::t_cfg lanes_cfg;
    t_lane_result   pending_results[$];

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        if (o_fail_count < PRINT_CAP) begin
            $display("mismatch %0s: got %0h expected %0h at %0t", what, got, want, $realtime);
        end
        o_fail_count++;
    endtask

    function automatic int unsigned active_lanes();
        if (lanes_cfg == 0) return 1;
        if (lanes_cfg > LANES) return LANES;
        return lanes_cfg;
    endfunction

    function automatic t_lane_result lane_result(mlfd_pkg::t_mode mode, mlfd_pkg::t_id id,
                                                 logic batch, mlfd_pkg::t_lane lane);
        t_lane_result r;
        int unsigned  act;
        int unsigned  l;
        int unsigned  top;
        int unsigned  seq;
        bit           found;
        r = '0;
        act = active_lanes();
        if (mode == mlfd_pkg::MODE_INSERT) begin
            if (batch) begin
                found = 1'b0;
                l = 0;
                for (int i = 0; i < act; i++) begin
                    if (!found && fill[i] == 0) begin
                        l = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    for (int i = 1; i < act; i++) begin
                        if (last_seq[i] < last_seq[l]) l = i;
                    end
                end
            end else begin
                l = (rr_lane < act) ? rr_lane : 0;
            end
            rr_lane = (l + 1 < act) ? l + 1 : 0;
            if (fill[l] >= DEPTH) begin
                r.status = mlfd_pkg::STATUS_FULL;
            end else begin
                top = 0;
                for (int i = 0; i < act; i++) begin
                    if (fill[i] != 0 && last_seq[i] > top) top = last_seq[i];
                end
                seq = (top >= SEQ_TOP) ? SEQ_TOP : top + 1;
                slot_id[l][wr_ptr[l]]  = id;
                slot_seq[l][wr_ptr[l]] = seq[15:0];
                wr_ptr[l]++;
                fill[l]++;
                last_seq[l] = seq[15:0];
                r.assigned  = seq[15:0];
                r.status    = mlfd_pkg::STATUS_OK;
            end
        end else if (mode == mlfd_pkg::MODE_REMOVE) begin
            l = lane;
            if (fill[l] == 0) begin
                r.status = mlfd_pkg::STATUS_EMPTY;
            end else begin
                rd_ptr[l]++;
                fill[l]--;
                if (fill[l] == 0) last_seq[l] = '0;
            end
        end else begin
            l = lane;
        end
        r.lane_used = mlfd_pkg::t_lane'(l);
        r.count     = fill[l];
        if (fill[l] != 0) begin
            r.head_id  = slot_id[l][rd_ptr[l]];
            r.head_seq = slot_seq[l][rd_ptr[l]];
            r.tail_seq = last_seq[l];
            r.empty    = 1'b0;
        end else begin
            r.empty = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_lane_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                rd_ptr[i]   = '0;
                wr_ptr[i]   = '0;
                fill[i]     = '0;
                last_seq[i] = '0;
            end
            rr_lane      = 0;
            lanes_cfg    = mlfd_pkg::CFG_LANES_RESET;
            o_fail_count = 0;
            pending_results.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) lanes_cfg = i_cfg.data;
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_results.size() == 0) begin
                    report("response without request", {62'b0, i_rsp.status}, 64'b0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_rsp.status !== want.status)
                        report("status", i_rsp.status, want.status);
                    if (i_rsp.lane_used !== want.lane_used)
                        report("lane_used", i_rsp.lane_used, want.lane_used);
                    if (i_rsp.assigned_sequence !== want.assigned)
                        report("assigned_sequence", i_rsp.assigned_sequence, want.assigned);
                    if (i_rsp.head_id !== want.head_id)
                        report("head_id", i_rsp.head_id, want.head_id);
                    if (i_rsp.head_sequence !== want.head_seq)
                        report("head_sequence", i_rsp.head_sequence, want.head_seq);
                    if (i_rsp.tail_sequence !== want.tail_seq)
                        report("tail_sequence", i_rsp.tail_sequence, want.tail_seq);
                    if (i_rsp.lane_count !== want.count)
                        report("lane_count", i_rsp.lane_count, want.count);
                    if (i_rsp.lane_empty !== want.empty)
                        report("lane_empty", i_rsp.lane_empty, want.empty);
                end
            end
            if (i_req.valid && i_req.ready) begin
                pending_results.push_back(lane_result(i_req.mode, i_req.item_id,
                                                      i_req.batch_start, i_req.lane));
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

// ===== test/tb_multi_lane_fifo_dispatcher.sv =====
// Testbench top for the multi-lane FIFO dispatcher: clock, reset, request and
// configuration stimulus, response back-pressure, watchdog and verdict.
// Depends on mlfd_pkg, mlfd_if, the block under test and mlfd_checker.
module tb_multi_lane_fifo_dispatcher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam mlfd_pkg::t_mode MODE_QUERY_ALT = 2'd3;
    localparam mlfd_pkg::t_id   ID_ONES        = {mlfd_pkg::ID_WIDTH{1'b1}};
    localparam int              QUIET_LIMIT    = 2000;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    int             fail_count;
    int             pending;
    int             send_idle;
    int             recv_idle;
    int             items_sent;
    mlfd_pkg::t_cfg lanes_now;
    mlfd_pkg::t_cfg plan [9] = '{3'd1, 3'd7, 3'd2, 3'd0, 3'd4, 3'd3, 3'd5, 3'd6, 3'd4};

    mlfd_cfg_if cfg ();
    mlfd_req_if req ();
    mlfd_rsp_if rsp ();

    multi_lane_fifo_dispatcher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    mlfd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_req        (req),
        .i_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    function automatic mlfd_pkg::t_id rand_id();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return ID_ONES;
            default: return mlfd_pkg::t_id'({$urandom, $urandom});
        endcase
    endfunction

    function automatic mlfd_pkg::t_lane pick_lane(int unsigned act);
        if ($urandom_range(0, 99) < 80) return mlfd_pkg::t_lane'($urandom_range(0, act - 1));
        return mlfd_pkg::t_lane'($urandom_range(0, 3));
    endfunction

    task automatic send_req(mlfd_pkg::t_mode m, mlfd_pkg::t_id id, logic b,
                            mlfd_pkg::t_lane l);
        if ($urandom_range(0, 99) < send_idle) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle) @(posedge i_clk);
        end
        req.valid       <= 1'b1;
        req.mode        <= m;
        req.item_id     <= id;
        req.batch_start <= b;
        req.lane        <= l;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_lanes(mlfd_pkg::t_cfg v);
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        lanes_now = v;
    endtask

    task automatic run_chunk(int n);
        int unsigned     act;
        int unsigned     r;
        int unsigned     len;
        int              stop;
        mlfd_pkg::t_lane fixed;
        act  = (lanes_now == 0) ? 1 : ((lanes_now > 4) ? 4 : lanes_now);
        stop = items_sent + n;
        send_req(mlfd_pkg::MODE_INSERT, rand_id(), 1'b0, mlfd_pkg::t_lane'($urandom_range(0, 3)));
        while (items_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                len = $urandom_range(1, 20);
                for (int i = 0; i < len; i++) begin
                    send_req(mlfd_pkg::MODE_INSERT, rand_id(),
                             (i == 0) ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 8),
                             mlfd_pkg::t_lane'($urandom_range(0, 3)));
                end
            end else if (r < 80) begin
                len   = $urandom_range(1, 12);
                fixed = pick_lane(act);
                for (int i = 0; i < len; i++) begin
                    send_req(mlfd_pkg::MODE_REMOVE, rand_id(), 1'($urandom_range(0, 1)),
                             $urandom_range(0, 1) ? fixed : pick_lane(act));
                end
            end else if (r < 90) begin
                send_req($urandom_range(0, 1) ? mlfd_pkg::MODE_QUERY : MODE_QUERY_ALT, rand_id(),
                         1'($urandom_range(0, 1)), pick_lane(act));
            end else if (r < 97) begin
                send_req(mlfd_pkg::t_mode'($urandom_range(0, 3)), rand_id(),
                         1'($urandom_range(0, 1)), mlfd_pkg::t_lane'($urandom_range(0, 3)));
            end else begin
                drain();
            end
        end
    endtask

    initial begin
        rsp.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            rsp.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
                (cfg.valid && cfg.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        req.valid       = 1'b0;
        req.mode        = mlfd_pkg::MODE_INSERT;
        req.item_id     = '0;
        req.batch_start = 1'b0;
        req.lane        = '0;
        cfg.valid       = 1'b0;
        cfg.data        = '0;
        send_idle       = 32;
        recv_idle       = 77;
        items_sent      = 0;
        lanes_now       = mlfd_pkg::CFG_LANES_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_req(mlfd_pkg::MODE_REMOVE, '0, 1'b0, 2'd0);
        send_req(mlfd_pkg::MODE_QUERY, ID_ONES, 1'b1, 2'd3);
        send_req(MODE_QUERY_ALT, '0, 1'b0, 2'd2);
        send_req(mlfd_pkg::MODE_INSERT, '0, 1'b1, 2'd0);
        send_req(mlfd_pkg::MODE_INSERT, ID_ONES, 1'b0, 2'd3);
        send_req(mlfd_pkg::MODE_INSERT, rand_id(), 1'b1, 2'd1);
        send_req(mlfd_pkg::MODE_INSERT, rand_id(), 1'b0, 2'd2);
        send_req(mlfd_pkg::MODE_INSERT, rand_id(), 1'b0, 2'd0);
        send_req(mlfd_pkg::MODE_INSERT, rand_id(), 1'b1, 2'd3);
        send_req(mlfd_pkg::MODE_QUERY, '0, 1'b0, 2'd0);
        send_req(mlfd_pkg::MODE_QUERY, '0, 1'b0, 2'd1);
        send_req(mlfd_pkg::MODE_REMOVE, '0, 1'b0, 2'd0);
        send_req(mlfd_pkg::MODE_REMOVE, '0, 1'b0, 2'd0);
        send_req(mlfd_pkg::MODE_REMOVE, '0, 1'b0, 2'd0);
        send_req(mlfd_pkg::MODE_REMOVE, '0, 1'b0, 2'd1);
        send_req(mlfd_pkg::MODE_REMOVE, '0, 1'b0, 2'd1);
        send_req(mlfd_pkg::MODE_REMOVE, '0, 1'b0, 2'd2);
        send_req(mlfd_pkg::MODE_REMOVE, '0, 1'b0, 2'd3);
        send_req(mlfd_pkg::MODE_INSERT, ID_ONES, 1'b1, 2'd2);
        send_req(mlfd_pkg::MODE_INSERT, rand_id(), 1'b0, 2'd1);
        send_req(mlfd_pkg::MODE_REMOVE, '0, 1'b1, 2'd3);

        for (int k = 0; k < 9; k++) begin
            if (k == 3) begin
                send_idle = 77;
                recv_idle = 32;
            end else if (k == 6) begin
                send_idle = 0;
                recv_idle = 0;
            end
            drain();
            write_lanes(plan[k]);
            run_chunk((k == 8) ? 60 : 80);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== multi_lane_fifo_dispatcher.f =====
hdl/mlfd_pkg.sv
hdl/mlfd_if.sv
hdl/mlfd_store.sv
hdl/multi_lane_fifo_dispatcher.sv
test/mlfd_checker.sv
test/tb_multi_lane_fifo_dispatcher.sv
